/* sv/cdiv_pkg.sv */
// ----------------------------------------------------------------------------
// cdiv_pkg
// Word types and pipeline control bundle shared by the complex divider.
// ----------------------------------------------------------------------------
package cdiv_pkg;

	// width of every payload part on the ports
	localparam int unsigned PORT_BITS = 32;

	// request word: dividend and divisor, signed fixed point
	typedef struct packed {
		logic signed [PORT_BITS-1:0] num_real;
		logic signed [PORT_BITS-1:0] num_imag;
		logic signed [PORT_BITS-1:0] den_real;
		logic signed [PORT_BITS-1:0] den_imag;
	} req_t;

	// response word: quotient and status flags
	typedef struct packed {
		logic signed [PORT_BITS-1:0] quot_real;
		logic signed [PORT_BITS-1:0] quot_imag;
		logic                        div_zero;
		logic                        overflowed;
	} rsp_t;

	// control bits that travel alongside the data down the cell chain
	typedef struct packed {
		logic valid;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
	} ctl_t;

endpackage

/* sv/cdiv_front.sv */
// ----------------------------------------------------------------------------
// cdiv_front
// Products, sums of products and divider setup, three pipeline stages.
// ----------------------------------------------------------------------------
module cdiv_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  cdiv_pkg::req_t       req,
	output cdiv_pkg::ctl_t       ctl_o,
	output logic [2*W-1:0]       den_o,
	output logic [2*W-1:0]       r_re_o,
	output logic [2*W-1:0]       r_im_o,
	output logic [W-1:0]         low_re_o,
	output logic [W-1:0]         low_im_o
);
	import cdiv_pkg::*;

	localparam int DW = 2*W + F;
	localparam int TW = W + F;
	localparam int CW = (TW > 2*W) ? TW : 2*W;

	logic signed [W-1:0] a, b, c, d;
	logic signed [2*W-1:0] ac_w, bd_w, bc_w, ad_w, cc_w, dd_w;
	logic signed [2*W-1:0] ac_s1, bd_s1, bc_s1, ad_s1, cc_s1, dd_s1;
	logic                  v_s1;
	logic signed [2*W:0]   sum_re, sum_im;
	logic [2*W:0]          abs_re, abs_im;
	logic [2*W-1:0]        mag_re_s2, mag_im_s2, den_s2;
	logic                  neg_re_s2, neg_im_s2, v_s2;
	logic [DW-1:0]         d_re, d_im;
	logic [TW-1:0]         top_re, top_im;
	ctl_t                  ctl_s3;
	logic [2*W-1:0]        den_s3, r_re_s3, r_im_s3;
	logic [W-1:0]          low_re_s3, low_im_s3;

	// used bits of each part
	assign a = req.num_real[W-1:0];
	assign b = req.num_imag[W-1:0];
	assign c = req.den_real[W-1:0];
	assign d = req.den_imag[W-1:0];

	// full width products
	assign ac_w = a * c;
	assign bd_w = b * d;
	assign bc_w = b * c;
	assign ad_w = a * d;
	assign cc_w = c * c;
	assign dd_w = d * d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ctl_s3 <= '0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			ctl_s3.valid <= v_s2;
			ctl_s3.dz <= (den_s2 == '0);
			ctl_s3.neg_re <= neg_re_s2;
			ctl_s3.neg_im <= neg_im_s2;
			ctl_s3.big_re <= (CW'(top_re) >= CW'(den_s2));
			ctl_s3.big_im <= (CW'(top_im) >= CW'(den_s2));
		end
	end

	// stage 1: product registers
	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1 <= ac_w;
			bd_s1 <= bd_w;
			bc_s1 <= bc_w;
			ad_s1 <= ad_w;
			cc_s1 <= cc_w;
			dd_s1 <= dd_w;
		end
	end

	// stage 2: signed sums to sign and magnitude, sum of squares
	assign sum_re = {ac_s1[2*W-1], ac_s1} + {bd_s1[2*W-1], bd_s1};
	assign sum_im = {bc_s1[2*W-1], bc_s1} - {ad_s1[2*W-1], ad_s1};
	assign abs_re = sum_re[2*W] ? (2*W+1)'(-sum_re) : sum_re;
	assign abs_im = sum_im[2*W] ? (2*W+1)'(-sum_im) : sum_im;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_re_s2 <= abs_re[2*W-1:0];
			mag_im_s2 <= abs_im[2*W-1:0];
			neg_re_s2 <= sum_re[2*W];
			neg_im_s2 <= sum_im[2*W];
			den_s2 <= cc_s1 + dd_s1;
		end
	end

	// stage 3: scaled dividend, range check and first partial remainder
	assign d_re = DW'(mag_re_s2) << F;
	assign d_im = DW'(mag_im_s2) << F;
	assign top_re = d_re[DW-1:W];
	assign top_im = d_im[DW-1:W];

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= den_s2;
			r_re_s3 <= (2*W)'(top_re);
			r_im_s3 <= (2*W)'(top_im);
			low_re_s3 <= d_re[W-1:0];
			low_im_s3 <= d_im[W-1:0];
		end
	end

	assign ctl_o = ctl_s3;
	assign den_o = den_s3;
	assign r_re_o = r_re_s3;
	assign r_im_o = r_im_s3;
	assign low_re_o = low_re_s3;
	assign low_im_o = low_im_s3;

endmodule

/* sv/cdiv_cell.sv */
// ----------------------------------------------------------------------------
// cdiv_cell
// One restoring division step for both quotient parts.
// ----------------------------------------------------------------------------
module cdiv_cell #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cdiv_pkg::ctl_t   ctl_i,
	input  logic [2*W-1:0]   den_i,
	input  logic [2*W-1:0]   r_re_i,
	input  logic [2*W-1:0]   r_im_i,
	input  logic [W-1:0]     low_re_i,
	input  logic [W-1:0]     low_im_i,
	input  logic [W-1:0]     q_re_i,
	input  logic [W-1:0]     q_im_i,
	output cdiv_pkg::ctl_t   ctl_o,
	output logic [2*W-1:0]   den_o,
	output logic [2*W-1:0]   r_re_o,
	output logic [2*W-1:0]   r_im_o,
	output logic [W-1:0]     low_re_o,
	output logic [W-1:0]     low_im_o,
	output logic [W-1:0]     q_re_o,
	output logic [W-1:0]     q_im_o
);
	import cdiv_pkg::*;

	logic [2*W:0]   sh_re, sh_im, dif_re, dif_im;
	logic           ge_re, ge_im;
	ctl_t           ctl_q;
	logic [2*W-1:0] den_q, r_re_q, r_im_q;
	logic [W-1:0]   low_re_q, low_im_q, q_re_q, q_im_q;

	// bring down next dividend bit and trial subtract
	assign sh_re = {r_re_i, low_re_i[W-1]};
	assign sh_im = {r_im_i, low_im_i[W-1]};
	assign dif_re = sh_re - {1'b0, den_i};
	assign dif_im = sh_im - {1'b0, den_i};
	assign ge_re = (sh_re >= {1'b0, den_i});
	assign ge_im = (sh_im >= {1'b0, den_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_i;
			r_re_q <= ge_re ? dif_re[2*W-1:0] : sh_re[2*W-1:0];
			r_im_q <= ge_im ? dif_im[2*W-1:0] : sh_im[2*W-1:0];
			low_re_q <= low_re_i << 1;
			low_im_q <= low_im_i << 1;
			q_re_q <= {q_re_i[W-2:0], ge_re};
			q_im_q <= {q_im_i[W-2:0], ge_im};
		end
	end

	assign ctl_o = ctl_q;
	assign den_o = den_q;
	assign r_re_o = r_re_q;
	assign r_im_o = r_im_q;
	assign low_re_o = low_re_q;
	assign low_im_o = low_im_q;
	assign q_re_o = q_re_q;
	assign q_im_o = q_im_q;

endmodule

/* sv/cdiv_back.sv */
// ----------------------------------------------------------------------------
// cdiv_back
// Saturation, sign restore and the response word register.
// ----------------------------------------------------------------------------
module cdiv_back #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cdiv_pkg::ctl_t   ctl_i,
	input  logic [W-1:0]     q_re_i,
	input  logic [W-1:0]     q_im_i,
	output logic             vld,
	output cdiv_pkg::rsp_t   rsp
);
	import cdiv_pkg::*;

	localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]        lim_re, lim_im, mag_re, mag_im;
	logic                sat_re, sat_im;
	logic signed [W-1:0] val_re, val_im;
	logic                vld_q;
	rsp_t                rsp_q;

	// clamp magnitude against the limit for its sign
	assign lim_re = ctl_i.neg_re ? LIM_NEG : LIM_POS;
	assign lim_im = ctl_i.neg_im ? LIM_NEG : LIM_POS;
	assign sat_re = ctl_i.big_re || (q_re_i > lim_re);
	assign sat_im = ctl_i.big_im || (q_im_i > lim_im);
	assign mag_re = sat_re ? lim_re : q_re_i;
	assign mag_im = sat_im ? lim_im : q_im_i;
	assign val_re = ctl_i.neg_re ? W'(-mag_re) : mag_re;
	assign val_im = ctl_i.neg_im ? W'(-mag_im) : mag_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctl_i.valid;
		end
	end

	// response word register
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_i.dz) begin
				rsp_q.quot_real <= '0;
				rsp_q.quot_imag <= '0;
				rsp_q.div_zero <= 1'b1;
				rsp_q.overflowed <= 1'b0;
			end else begin
				rsp_q.quot_real <= PORT_BITS'(val_re);
				rsp_q.quot_imag <= PORT_BITS'(val_im);
				rsp_q.div_zero <= 1'b0;
				rsp_q.overflowed <= sat_re || sat_im;
			end
		end
	end

	assign vld = vld_q;
	assign rsp = rsp_q;

endmodule

/* sv/complex_divider.sv */
// ----------------------------------------------------------------------------
// complex_divider
// Pipelined complex division in signed fixed point with saturation.
// ----------------------------------------------------------------------------
//  channel   handshake               word
//  request   req_valid / req_stall   req_word  (dividend, divisor)
//  response  rsp_valid / rsp_stall   rsp_word  (quotient, div_zero, overflowed)
//
//  one word per cycle while the response is not stalled; 3 front stages, one
//  division cell per quotient bit, one output register
//  the chain of WORD_BITS division cells lies between the front and the output register
//  reset clears only the valid and control bits; no clearing pass
//  a stalled response freezes the whole pipeline and stalls the request side
// ----------------------------------------------------------------------------
module complex_divider #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  cdiv_pkg::req_t   req_word,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output cdiv_pkg::rsp_t   rsp_word
);
	import cdiv_pkg::*;

	localparam int W = WORD_BITS;
	localparam logic signed [PORT_BITS-1:0] MAX_Q =
		PORT_BITS'((64'sd1 <<< (W-1)) - 64'sd1);
	localparam logic signed [PORT_BITS-1:0] MIN_Q = -MAX_Q - 1;

	logic           en;
	ctl_t           ctl    [W+1];
	logic [2*W-1:0] den    [W+1];
	logic [2*W-1:0] r_re   [W+1];
	logic [2*W-1:0] r_im   [W+1];
	logic [W-1:0]   low_re [W+1];
	logic [W-1:0]   low_im [W+1];
	logic [W-1:0]   q_re   [W+1];
	logic [W-1:0]   q_im   [W+1];

	// pipeline moves unless a finished word is held
	assign en = !rsp_valid || !rsp_stall;
	assign req_stall = !en;

	cdiv_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (req_valid),
		.req      (req_word),
		.ctl_o    (ctl[0]),
		.den_o    (den[0]),
		.r_re_o   (r_re[0]),
		.r_im_o   (r_im[0]),
		.low_re_o (low_re[0]),
		.low_im_o (low_im[0])
	);

	assign q_re[0] = '0;
	assign q_im[0] = '0;

	// one cell per quotient bit, most significant first
	for (genvar i = 0; i < W; i++) begin : g_cell
		cdiv_cell #(.W(W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl[i]),
			.den_i    (den[i]),
			.r_re_i   (r_re[i]),
			.r_im_i   (r_im[i]),
			.low_re_i (low_re[i]),
			.low_im_i (low_im[i]),
			.q_re_i   (q_re[i]),
			.q_im_i   (q_im[i]),
			.ctl_o    (ctl[i+1]),
			.den_o    (den[i+1]),
			.r_re_o   (r_re[i+1]),
			.r_im_o   (r_im[i+1]),
			.low_re_o (low_re[i+1]),
			.low_im_o (low_im[i+1]),
			.q_re_o   (q_re[i+1]),
			.q_im_o   (q_im[i+1])
		);
	end

	cdiv_back #(.W(W)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl[W]),
		.q_re_i (q_re[W]),
		.q_im_i (q_im[W]),
		.vld    (rsp_valid),
		.rsp    (rsp_word)
	);

	// zero divisor gives a zero quotient and no overflow
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.div_zero |->
		rsp_word.quot_real == '0 && rsp_word.quot_imag == '0 && !rsp_word.overflowed)
		else $error("zero divisor word not cleared");

	// overflow leaves at least one part at a limit
	a_ovf_lim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.overflowed |->
		rsp_word.quot_real == MAX_Q || rsp_word.quot_real == MIN_Q ||
		rsp_word.quot_imag == MAX_Q || rsp_word.quot_imag == MIN_Q)
		else $error("overflow flag without saturated part");

	// request side stalls exactly when a finished word is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("request stall out of step with response");

	// a held word still stands in the next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("held response word dropped");

endmodule

/* dv/cdiv_checker.sv */
// ----------------------------------------------------------------------------
// cdiv_checker
// Watches both channels of the complex divider, predicts each quotient from
// the accepted request word and compares the response words in order.
// ----------------------------------------------------------------------------
module cdiv_checker #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  cdiv_pkg::req_t req_word,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  cdiv_pkg::rsp_t rsp_word,
	output int             errors,
	output int             pending
);
	import cdiv_pkg::*;

	rsp_t quot_fifo[$];

	assign pending = quot_fifo.size();

	// sign-extend the low WORD_BITS bits of a port part
	function automatic logic signed [63:0] part_value(logic [31:0] raw);
		logic [63:0] v;
		v = 64'(raw) & ((64'd1 << WORD_BITS) - 1);
		if (v[WORD_BITS-1])
			v = v | ~((64'd1 << WORD_BITS) - 1);
		return $signed(v);
	endfunction

	// truncated, saturated ratio scaled by 2^FRAC_BITS
	function automatic logic signed [63:0] scaled_ratio(logic [127:0] mag, logic neg,
			logic [127:0] den, ref logic sat);
		logic [127:0] lim;
		logic [127:0] q;
		lim = neg ? (128'd1 << (WORD_BITS - 1)) : ((128'd1 << (WORD_BITS - 1)) - 1);
		q = (mag << FRAC_BITS) / den;
		if (q > lim) begin
			q = lim;
			sat = 1'b1;
		end
		return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic rsp_t predict_quotient(req_t r);
		logic signed [127:0] a, b, c, d, sr, si;
		logic [127:0] den;
		logic sat;
		rsp_t res;
		a = part_value(r.num_real);
		b = part_value(r.num_imag);
		c = part_value(r.den_real);
		d = part_value(r.den_imag);
		den = c * c + d * d;
		res = '0;
		if (den == 0) begin
			res.div_zero = 1'b1;
			return res;
		end
		sat = 1'b0;
		sr = a * c + b * d;
		si = b * c - a * d;
		res.quot_real = 32'(scaled_ratio(sr < 0 ? -sr : sr, sr < 0, den, sat));
		res.quot_imag = 32'(scaled_ratio(si < 0 ? -si : si, si < 0, den, sat));
		res.overflowed = sat;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial errors = 0;

	// predict on request, compare on response
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				quot_fifo.push_back(predict_quotient(req_word));
			if (rsp_valid && !rsp_stall) begin
				if (quot_fifo.size() == 0) begin
					report_mismatch("unexpected word", rsp_word.quot_real, 32'd0);
				end else begin
					want = quot_fifo.pop_front();
					if (rsp_word.quot_real !== want.quot_real)
						report_mismatch("quot_real", rsp_word.quot_real, want.quot_real);
					if (rsp_word.quot_imag !== want.quot_imag)
						report_mismatch("quot_imag", rsp_word.quot_imag, want.quot_imag);
					if (rsp_word.div_zero !== want.div_zero)
						report_mismatch("div_zero", 32'(rsp_word.div_zero),
							32'(want.div_zero));
					if (rsp_word.overflowed !== want.overflowed)
						report_mismatch("overflowed", 32'(rsp_word.overflowed),
							32'(want.overflowed));
				end
			end
		end
	end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random divisions into the complex divider with random
// idling on both channels, a long response hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
	import cdiv_pkg::*;

	localparam int LATENCY    = 36;
	localparam int N_RANDOM   = 1000;
	localparam int IDLE_LIMIT = 5000;

	logic clk, arst_n, req_valid, req_stall, rsp_valid, rsp_stall;
	req_t req_word;
	rsp_t rsp_word;
	int   errors, pending;
	int   quiet = 0;
	logic calm, hold_rsp, sent_all;

	complex_divider dut (.*);

	cdiv_checker chk (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(0, 8)) - 4);
			3: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
			4: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return $urandom();
		endcase
	endfunction

	// one word offered until accepted, at random after a burst of idling first
	task automatic send_word(req_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic send_parts(logic [31:0] a, b, c, d);
		req_t w;
		w = '{a, b, c, d};
		send_word(w);
	endtask

	// response side stall, random bursts or a long hold-off
	initial begin
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (100) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || sent_all && pending == 0)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_word = '0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		sent_all = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero divisor, extremes, tiny negatives, saturation
		send_parts(32'h0001_0000, 32'h0002_0000, 0, 0);
		send_parts(32'h8000_0000, 32'h8000_0000, 0, 0);
		send_parts(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
		send_parts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_parts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_parts(32'h7fff_ffff, 32'h8000_0000, 1, 0);
		send_parts(32'h8000_0000, 32'h7fff_ffff, 0, 1);
		send_parts(32'h8000_0000, 0, 32'hffff_ffff, 0);
		send_parts(32'hffff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000);
		send_parts(1, 32'hffff_ffff, 32'h7fff_0000, 32'h7fff_0000);
		send_parts(32'h0001_0000, 0, 32'h0001_0000, 0);
		send_parts(0, 32'h0001_0000, 0, 32'hffff_0000);
		send_parts(32'hffff_0000, 0, 32'h0002_0000, 0);
		send_parts(32'h7fff_ffff, 0, 32'h0000_8000, 0);
		send_parts(32'h8000_0000, 0, 32'h0000_8000, 0);
		send_parts(0, 0, 32'h8000_0000, 0);

		// long response hold-off while requests keep coming
		hold_rsp = 1'b1;
		repeat (80) send_parts(rand_part(), rand_part(), rand_part(), rand_part());

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// drain pause
				req_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			if (i == N_RANDOM - 150)
				calm = 1'b1;
			if ($urandom_range(0, 19) == 0)
				send_parts(rand_part(), rand_part(), 0, 0);
			else
				send_parts(rand_part(), rand_part(), rand_part(), rand_part());
		end
		req_valid <= 1'b0;
		sent_all = 1'b1;
		wait (pending == 0);
		repeat (LATENCY + 4) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/cdiv_pkg.sv
sv/cdiv_front.sv
sv/cdiv_cell.sv
sv/cdiv_back.sv
sv/complex_divider.sv
dv/cdiv_checker.sv
dv/tb_top.sv
